[rtl/fva_pkg.sv]
// ----------------------------------------------------------------------------
// fva_pkg
// Shared types and constants of the fisheye vignette alpha pipeline.
// ----------------------------------------------------------------------------
package fva_pkg;

  localparam int AlphaW = 16;
  localparam int QuotW  = 16;
  localparam logic [AlphaW-1:0] OneQ15 = 16'h8000;

  typedef enum logic [2:0] {
    RegCenterX     = 3'd0,
    RegCenterY     = 3'd1,
    RegFadeStart   = 3'd2,
    RegFadeEnd     = 3'd3,
    RegEdgeZero    = 3'd4,
    RegEdgeRamp    = 3'd5,
    RegImageWidth  = 3'd6,
    RegImageHeight = 3'd7
  } fva_reg_e;

  typedef struct packed {
    logic rad_one;
    logic rad_zero;
    logic rad_sat;
    logic edge_on;
    logic edge_one;
    logic edge_zero;
  } fva_flags_t;

endpackage

[rtl/fva_front.sv]
// ----------------------------------------------------------------------------
// fva_front
// Center offsets, border distance, squares and their sum over three stages.
// ----------------------------------------------------------------------------
module fva_front #(
  parameter int CW = 12,
  parameter int FW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [CW-1:0]         x_i,
  input  logic [CW-1:0]         y_i,
  input  logic [CW+FW-1:0]      cx_i,
  input  logic [CW+FW-1:0]      cy_i,
  input  logic [CW:0]           w_i,
  input  logic [CW:0]           h_i,
  output logic                  valid_o,
  output logic [2*(CW+FW):0]    sum_o,
  output logic [CW:0]           d_o
);

  localparam int PW = CW + FW;

  logic [PW-1:0]    xs, ys, adx_d, ady_d, adx_q, ady_q;
  logic signed [CW+1:0] ex, ey;
  logic [CW+1:0]    ax, ay, m0, m1, m2, m3;
  logic [CW:0]      d_d, d1_q, d2_q, d3_q;
  logic [2*PW-1:0]  sqx_q, sqy_q;
  logic [2*PW:0]    sum_q;
  logic [2:0]       vld_q;

  always_comb begin
    xs    = PW'(x_i) << FW;
    ys    = PW'(y_i) << FW;
    adx_d = (xs >= cx_i) ? xs - cx_i : cx_i - xs;
    ady_d = (ys >= cy_i) ? ys - cy_i : cy_i - ys;
    ex    = $signed({2'b00, x_i}) - $signed({1'b0, w_i}) + (CW+2)'(1);
    ey    = $signed({2'b00, y_i}) - $signed({1'b0, h_i}) + (CW+2)'(1);
    ax    = ex[CW+1] ? (CW+2)'(-ex) : (CW+2)'(ex);
    ay    = ey[CW+1] ? (CW+2)'(-ey) : (CW+2)'(ey);
    m0    = ((CW+2)'(w_i) < (CW+2)'(x_i)) ? (CW+2)'(w_i) : (CW+2)'(x_i);
    m1    = (m0 < (CW+2)'(y_i)) ? m0 : (CW+2)'(y_i);
    m2    = (m1 < ax) ? m1 : ax;
    m3    = (m2 < ay) ? m2 : ay;
    d_d   = m3[CW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q <= adx_d;
      ady_q <= ady_d;
      d1_q  <= d_d;
      sqx_q <= adx_q * adx_q;
      sqy_q <= ady_q * ady_q;
      d2_q  <= d1_q;
      sum_q <= (2*PW+1)'(sqx_q) + (2*PW+1)'(sqy_q);
      d3_q  <= d2_q;
    end
  end

  assign valid_o = vld_q[2];
  assign sum_o   = sum_q;
  assign d_o     = d3_q;

endmodule

[rtl/fva_sqrt.sv]
// ----------------------------------------------------------------------------
// fva_sqrt
// Floor square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module fva_sqrt #(
  parameter int RW = 17,
  parameter int DW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [DW-1:0]   d_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [DW-1:0]   d_o
);

  localparam int SW = 2 * RW;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] rad_q  [RW];
  logic [DW-1:0] d_q    [RW];
  logic [RW-1:0] vld_q;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_in, remx, trial;
    logic [RW-1:0] root_in;
    logic [SW-1:0] rad_in;
    logic [DW-1:0] d_in;
    logic          v_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign d_in    = d_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign d_in    = d_q[k-1];
      assign v_in    = vld_q[k-1];
    end

    always_comb begin
      remx  = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
      trial = {root_in, 2'b01};
      ge    = remx >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? remx - trial : remx;
        root_q[k] <= {root_in[RW-2:0], ge};
        rad_q[k]  <= rad_in << 2;
        d_q[k]    <= d_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign d_o     = d_q[RW-1];

endmodule

[rtl/fva_div.sv]
// ----------------------------------------------------------------------------
// fva_div
// Two-lane restoring divider, one quotient bit per stage, Q15 fractions.
// ----------------------------------------------------------------------------
module fva_div
  import fva_pkg::*;
#(
  parameter int DW = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fva_flags_t       flags_i,
  input  logic [DW-1:0]    num0_i,
  input  logic [DW-1:0]    div0_i,
  input  logic [DW-1:0]    num1_i,
  input  logic [DW-1:0]    div1_i,
  output logic             valid_o,
  output fva_flags_t       flags_o,
  output logic [QuotW-1:0] q0_o,
  output logic [QuotW-1:0] q1_o
);

  logic [DW-1:0]    rem0_q [QuotW];
  logic [DW-1:0]    rem1_q [QuotW];
  logic [DW-1:0]    dv0_q  [QuotW];
  logic [DW-1:0]    dv1_q  [QuotW];
  logic [QuotW-1:0] q0_q   [QuotW];
  logic [QuotW-1:0] q1_q   [QuotW];
  fva_flags_t       fl_q   [QuotW];
  logic [QuotW-1:0] vld_q;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [DW-1:0]    r0x, r1x, d0, d1;
    logic [QuotW-1:0] qa, qb;
    fva_flags_t       fl;
    logic             v_in, b0, b1;

    if (k == 0) begin : g_first
      assign r0x  = num0_i;
      assign r1x  = num1_i;
      assign d0   = div0_i;
      assign d1   = div1_i;
      assign qa   = '0;
      assign qb   = '0;
      assign fl   = flags_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r0x  = rem0_q[k-1] << 1;
      assign r1x  = rem1_q[k-1] << 1;
      assign d0   = dv0_q[k-1];
      assign d1   = dv1_q[k-1];
      assign qa   = q0_q[k-1];
      assign qb   = q1_q[k-1];
      assign fl   = fl_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign b0 = r0x >= d0;
    assign b1 = r1x >= d1;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem0_q[k] <= b0 ? r0x - d0 : r0x;
        rem1_q[k] <= b1 ? r1x - d1 : r1x;
        dv0_q[k]  <= d0;
        dv1_q[k]  <= d1;
        q0_q[k]   <= {qa[QuotW-2:0], b0};
        q1_q[k]   <= {qb[QuotW-2:0], b1};
        fl_q[k]   <= fl;
      end
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign flags_o = fl_q[QuotW-1];
  assign q0_o    = q0_q[QuotW-1];
  assign q1_o    = q1_q[QuotW-1];

endmodule

[rtl/fisheye_vignette_alpha.sv]
// ----------------------------------------------------------------------------
// fisheye_vignette_alpha
// Per-pixel vignette weight from radial fade and border ramp, Q1.15.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    pixel_x, pixel_y
//  m_axis    out  m_axis_tvalid/tready    alpha
//  cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle unless m_axis stalls; items pass the front end, the
// bit-per-stage square root, a flag stage, the bit-per-stage divider and the
// output registers. Reset clears all valid bits and loads register defaults.
// A stall on m_axis holds the whole pipeline; cfg writes are always taken.
// ----------------------------------------------------------------------------
module fisheye_vignette_alpha
  import fva_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4,
  localparam int InW       = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int RegW      = COORD_BITS + FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InW-1:0]     s_axis_tdata,   // pixel_x, pixel_y
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [AlphaW-1:0]  m_axis_tdata,   // alpha
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [RegW-1:0]    cfg_data_i
);

  localparam int CW   = COORD_BITS;
  localparam int PW   = COORD_BITS + FRAC_BITS;
  localparam int RW   = PW + 1;
  localparam int DW   = CW + 1;
  localparam int DivW = RW + 1;

  logic [PW-1:0] cx_q, cy_q;
  logic [RW-1:0] start_q, end_q;
  logic [CW-1:0] e0_q, e1_q;
  logic [CW:0]   w_q, h_q;

  logic en;
  logic f_valid, s_valid, d_valid;
  logic [2*PW:0] f_sum;
  logic [DW-1:0] f_d, s_d;
  logic [RW-1:0] s_root;

  logic          st_valid_q;
  fva_flags_t    st_flags_q, st_flags_d, dv_flags;
  logic [DivW-1:0] n0_q, v0_q, n1_q, v1_q;
  logic [RW-1:0]   diff, dspan;
  logic [QuotW-1:0] q0, q1;

  logic [AlphaW-1:0] arad_d, ramp_d, fall;
  logic [AlphaW-1:0] arad_q, ramp_q;
  logic              eon_q, mv_q;
  logic [2*AlphaW-1:0] prod;
  logic [AlphaW-1:0] out_q;
  logic              ov_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= PW'(32768);
      cy_q    <= PW'(32768);
      start_q <= RW'(16384);
      end_q   <= RW'(32768);
      e0_q    <= '0;
      e1_q    <= CW'(16);
      w_q     <= DW'(1024);
      h_q     <= DW'(1024);
    end else if (cfg_valid_i) begin
      unique case (fva_reg_e'(cfg_index_i))
        RegCenterX:     cx_q    <= cfg_data_i[PW-1:0];
        RegCenterY:     cy_q    <= cfg_data_i[PW-1:0];
        RegFadeStart:   start_q <= cfg_data_i[RW-1:0];
        RegFadeEnd:     end_q   <= cfg_data_i[RW-1:0];
        RegEdgeZero:    e0_q    <= cfg_data_i[CW-1:0];
        RegEdgeRamp:    e1_q    <= cfg_data_i[CW-1:0];
        RegImageWidth:  w_q     <= cfg_data_i[CW:0];
        RegImageHeight: h_q     <= cfg_data_i[CW:0];
      endcase
    end
  end

  fva_front #(.CW(CW), .FW(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid),
    .x_i(s_axis_tdata[CW-1:0]),
    .y_i(s_axis_tdata[2*CW-1:CW]),
    .cx_i(cx_q), .cy_i(cy_q), .w_i(w_q), .h_i(h_q),
    .valid_o(f_valid), .sum_o(f_sum), .d_o(f_d)
  );

  fva_sqrt #(.RW(RW), .DW(DW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid), .rad_i((2*RW)'(f_sum)), .d_i(f_d),
    .valid_o(s_valid), .root_o(s_root), .d_o(s_d)
  );

  always_comb begin
    diff  = s_root - start_q;
    dspan = end_q - start_q;
    st_flags_d.rad_one   = (s_root <= start_q) || (end_q < start_q);
    st_flags_d.rad_zero  = (s_root > start_q) && (end_q == start_q);
    st_flags_d.rad_sat   = {1'b0, diff} >= {dspan, 1'b0};
    st_flags_d.edge_on   = s_d < DW'(e1_q);
    st_flags_d.edge_one  = e0_q > e1_q;
    st_flags_d.edge_zero = s_d <= DW'(e0_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (en) begin
      st_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_flags_q <= st_flags_d;
      n0_q       <= DivW'(diff);
      v0_q       <= DivW'(dspan);
      n1_q       <= DivW'(s_d - DW'(e0_q));
      v1_q       <= DivW'(e1_q - e0_q);
    end
  end

  fva_div #(.DW(DivW)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(st_valid_q), .flags_i(st_flags_q),
    .num0_i(n0_q), .div0_i(v0_q), .num1_i(n1_q), .div1_i(v1_q),
    .valid_o(d_valid), .flags_o(dv_flags), .q0_o(q0), .q1_o(q1)
  );

  always_comb begin
    fall = (dv_flags.rad_sat || q0 > OneQ15) ? OneQ15 : q0;
    priority if (dv_flags.rad_one) begin
      arad_d = OneQ15;
    end else if (dv_flags.rad_zero) begin
      arad_d = '0;
    end else begin
      arad_d = OneQ15 - fall;
    end
    priority if (dv_flags.edge_one) begin
      ramp_d = OneQ15;
    end else if (dv_flags.edge_zero) begin
      ramp_d = '0;
    end else begin
      ramp_d = q1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      mv_q <= d_valid;
      ov_q <= mv_q;
    end
  end

  assign prod = arad_q * ramp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      arad_q <= arad_d;
      ramp_q <= ramp_d;
      eon_q  <= dv_flags.edge_on;
      out_q  <= eon_q ? prod[AlphaW+14:15] : arad_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= OneQ15)
    else $error("alpha above one");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_rad_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid_q |-> !(st_flags_q.rad_one && st_flags_q.rad_zero))
    else $error("radial cases overlap");

endmodule
